// ===== rtl/conv2d_window_stream_core_assert.svh =====
// assertion macros for the conv2d window stream core
`ifndef CONV2D_WINDOW_STREAM_CORE_ASSERT_SVH
`define CONV2D_WINDOW_STREAM_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked on clk_i, disabled while rst_ni is low
`define C2DWS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition that must never hold
`define C2DWS_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define C2DWS_ASSERT(name, prop, msg)
`define C2DWS_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ===== rtl/c2dws_pkg.sv =====
package c2dws_pkg;

  // kernel geometry is fixed by the coefficient register layout
  localparam int KSIZE = 3;
  localparam int NTAPS = KSIZE * KSIZE;
  localparam int PAD   = KSIZE - 1 - KSIZE / 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int QDEPTH         = 4;

  localparam int PIX_W  = 16;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 36;
  localparam int IDX_W  = 10;
  localparam int SIZE_W = 11;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;

  localparam logic [2:0] REG_EDGE_MODE = 3'd0;
  localparam logic [2:0] REG_WIDTH     = 3'd1;
  localparam logic [2:0] REG_HEIGHT    = 3'd2;
  localparam logic [2:0] REG_COEF0     = 3'd3;
  localparam logic [2:0] REG_COEF1     = 3'd4;
  localparam logic [2:0] REG_COEF2     = 3'd5;

  localparam logic [PIX_W-1:0] COEF_ONE = 16'h0100;

  typedef struct packed {
    logic                        edge_mode;
    logic [SIZE_W-1:0]           image_width;
    logic [SIZE_W-1:0]           image_height;
    logic [NTAPS-1:0][PIX_W-1:0] coef;
  } cfg_t;

  typedef struct packed {
    logic             emit0;
    logic             emit1;
    logic             last0;
    logic             last1;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col0;
    logic [IDX_W-1:0] col1;
  } res_meta_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [NTAPS-1:0] mask0;
    logic [NTAPS-1:0] mask1;
    res_meta_t        meta;
  } task_t;

  localparam int TASK_W = $bits(task_t);

endpackage

// ===== rtl/c2dws_if.sv =====
interface c2dws_in_if;
  import c2dws_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [PIX_W-1:0] pixel;
  modport source (output valid, output cmd, output pixel, input ready);
  modport sink (input valid, input cmd, input pixel, output ready);
endinterface

interface c2dws_out_if;
  import c2dws_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum_value;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic                    frame_last;
  modport source (output valid, output sum_value, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink (input valid, input sum_value, input out_row, input out_col,
                input frame_last, output ready);
endinterface

// ===== rtl/c2dws_front.sv =====
module c2dws_front
  import c2dws_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  c2dws_in_if.sink        in_i,
  input  logic            full_i,
  output logic            push_o,
  output logic [AW-1:0]   addr_o,
  output task_t           task_o
);

  localparam int CNT_W = (RW > AW) ? RW : AW;
  localparam int SW    = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 2;
  localparam logic signed [SW-1:0] MAXW_S = SW'(MAX_WIDTH);
  localparam logic signed [SW-1:0] MAXH_S = SW'(MAX_HEIGHT);

  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] col_q, col_d;
  logic signed [SW-1:0] iw_s, ih_s, w_s, h_s, r_s, c_s, last_row;
  logic eor, eof;
  logic [KSIZE-1:0] rowok, colok0, colok1;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign addr_o     = col_q;

  always_comb begin
    iw_s = $signed(SW'(cfg_i.image_width));
    ih_s = $signed(SW'(cfg_i.image_height));
    // out-of-range sizes clamp to one and to the maximum
    if (iw_s == '0) begin
      w_s = SW'(1);
    end else if (iw_s > MAXW_S) begin
      w_s = MAXW_S;
    end else begin
      w_s = iw_s;
    end
    if (ih_s == '0) begin
      h_s = SW'(1);
    end else if (ih_s > MAXH_S) begin
      h_s = MAXH_S;
    end else begin
      h_s = ih_s;
    end
    r_s = $signed(SW'(row_q));
    c_s = $signed(SW'(col_q));
    eor = c_s >= (w_s - 1);
    last_row = cfg_i.edge_mode ? SW'(h_s - 1 + PAD) : SW'(h_s - 1);
    eof = eor && (r_s >= last_row);

    // taps outside the image are masked
    for (int k = 0; k < KSIZE; k++) begin
      rowok[k]  = (r_s - (KSIZE - 1) + k >= 0) && (r_s - (KSIZE - 1) + k < h_s);
      colok0[k] = (c_s - (KSIZE - 1) + k >= 0) && (c_s - (KSIZE - 1) + k < w_s);
      colok1[k] = (k + PAD < KSIZE) && (c_s - (KSIZE - 1) + PAD + k >= 0) &&
                  (c_s - (KSIZE - 1) + PAD + k < w_s);
    end
    for (int kr = 0; kr < KSIZE; kr++) begin
      for (int kc = 0; kc < KSIZE; kc++) begin
        task_o.mask0[kr*KSIZE+kc] = rowok[kr] && colok0[kc];
        task_o.mask1[kr*KSIZE+kc] = rowok[kr] && colok1[kc];
      end
    end

    task_o.pix = in_i.cmd ? '0 : in_i.pixel;
    task_o.meta.col1 = IDX_W'(c_s);
    if (!cfg_i.edge_mode) begin
      task_o.meta.emit0 = (r_s >= KSIZE - 1) && (c_s >= KSIZE - 1);
      task_o.meta.emit1 = 1'b0;
      task_o.meta.last0 = eof;
      task_o.meta.last1 = 1'b0;
      task_o.meta.row   = IDX_W'(r_s - (KSIZE - 1));
      task_o.meta.col0  = IDX_W'(c_s - (KSIZE - 1));
    end else begin
      task_o.meta.emit0 = (r_s >= PAD) && (c_s >= PAD);
      task_o.meta.emit1 = (r_s >= PAD) && eor;
      task_o.meta.last0 = 1'b0;
      task_o.meta.last1 = eof;
      task_o.meta.row   = IDX_W'(r_s - PAD);
      task_o.meta.col0  = IDX_W'(c_s - PAD);
    end

    row_d = row_q;
    col_d = col_q;
    if (push_o) begin
      if (eor) begin
        col_d = '0;
        row_d = (r_s >= last_row) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ===== rtl/c2dws_queue.sv =====
module c2dws_queue
  import c2dws_pkg::*;
#(
  parameter int WIDTH = TASK_W,
  parameter int DEPTH = QDEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [PW:0]      cnt_q;

  assign full_o  = cnt_q == (PW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/c2dws_back.sv =====
`include "conv2d_window_stream_core_assert.svh"

module c2dws_back
  import c2dws_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            empty_i,
  input  logic [AW-1:0]   addr_i,
  input  task_t           task_i,
  output logic            pop_o,
  c2dws_out_if.source     out_o
);

  localparam int LW = (KSIZE - 1) * PIX_W;
  localparam int RS_W = PROD_W + 2;

  // line store: one word per column holds both earlier rows
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] mem_rd_q, byp_data_q, line_word, wr_data;
  logic          byp_q, wr_en;

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  task_t t1_q;
  logic [AW-1:0] a1_q;
  logic [NTAPS-1:0] m0_2_q, m1_2_q;
  res_meta_t meta2_q, meta3_q, meta4_q, meta5_q;
  logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] win_q;

  logic signed [PROD_W-1:0] p0_q [NTAPS];
  logic signed [PROD_W-1:0] p1_q [NTAPS];
  logic signed [RS_W-1:0]   r0_q [KSIZE];
  logic signed [RS_W-1:0]   r1_q [KSIZE];
  logic signed [SUM_W-1:0]  sum0_q, sum1_q;

  logic s0_q, s1_q, s0_d, s1_d;
  logic signed [SUM_W-1:0] osum0_q, osum1_q;
  res_meta_t ometa_q;

  assign adv   = !(s0_q || s1_q) || (out_o.ready && !(s0_q && s1_q));
  assign pop_o = adv && !empty_i;
  assign wr_en = adv && v1_q;

  assign line_word = byp_q ? byp_data_q : mem_rd_q;
  assign wr_data   = {t1_q.pix, line_word[LW-1:PIX_W]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[a1_q] <= wr_data;
    end
    if (adv) begin
      mem_rd_q   <= line_mem[addr_i];
      byp_data_q <= wr_data;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q    <= task_i;
      a1_q    <= addr_i;
      m0_2_q  <= t1_q.mask0;
      m1_2_q  <= t1_q.mask1;
      meta2_q <= t1_q.meta;
      meta3_q <= meta2_q;
      meta4_q <= meta3_q;
      meta5_q <= meta4_q;
      for (int kr = 0; kr < KSIZE; kr++) begin
        for (int kc = 0; kc < KSIZE; kc++) begin
          // signed zero keeps the product signed
          p0_q[kr*KSIZE+kc] <= m0_2_q[kr*KSIZE+kc] ?
            $signed(win_q[kr][kc]) * $signed(cfg_i.coef[kr*KSIZE+kc]) :
            $signed(PROD_W'(0));
          // shifted window for the trailing column of a row
          p1_q[kr*KSIZE+kc] <= m1_2_q[kr*KSIZE+kc] ?
            $signed(win_q[kr][(kc+PAD)%KSIZE]) * $signed(cfg_i.coef[kr*KSIZE+kc]) :
            $signed(PROD_W'(0));
        end
      end
      for (int kr = 0; kr < KSIZE; kr++) begin
        r0_q[kr] <= RS_W'(p0_q[kr*KSIZE]) + RS_W'(p0_q[kr*KSIZE+1]) +
                    RS_W'(p0_q[kr*KSIZE+2]);
        r1_q[kr] <= RS_W'(p1_q[kr*KSIZE]) + RS_W'(p1_q[kr*KSIZE+1]) +
                    RS_W'(p1_q[kr*KSIZE+2]);
      end
      sum0_q  <= SUM_W'(r0_q[0]) + SUM_W'(r0_q[1]) + SUM_W'(r0_q[2]);
      sum1_q  <= SUM_W'(r1_q[0]) + SUM_W'(r1_q[1]) + SUM_W'(r1_q[2]);
      osum0_q <= sum0_q;
      osum1_q <= sum1_q;
      ometa_q <= meta5_q;
    end
  end

  always_comb begin
    s0_d = s0_q;
    s1_d = s1_q;
    if (adv) begin
      s0_d = v5_q && meta5_q.emit0;
      s1_d = v5_q && meta5_q.emit1;
    end else if (out_o.ready) begin
      if (s0_q) begin
        s0_d = 1'b0;
      end else begin
        s1_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      s0_q  <= 1'b0;
      s1_q  <= 1'b0;
      byp_q <= 1'b0;
      win_q <= '0;
    end else begin
      s0_q <= s0_d;
      s1_q <= s1_d;
      if (adv) begin
        v1_q  <= pop_o;
        v2_q  <= v1_q;
        v3_q  <= v2_q;
        v4_q  <= v3_q;
        v5_q  <= v4_q;
        byp_q <= wr_en && (a1_q == addr_i);
        if (v1_q) begin
          for (int kr = 0; kr < KSIZE; kr++) begin
            for (int kc = 0; kc < KSIZE - 1; kc++) begin
              win_q[kr][kc] <= win_q[kr][kc+1];
            end
          end
          for (int l = 0; l < KSIZE - 1; l++) begin
            win_q[l][KSIZE-1] <= line_word[l*PIX_W +: PIX_W];
          end
          win_q[KSIZE-1][KSIZE-1] <= t1_q.pix;
        end
      end
    end
  end

  assign out_o.valid      = s0_q || s1_q;
  assign out_o.sum_value  = s0_q ? osum0_q : osum1_q;
  assign out_o.out_row    = ometa_q.row;
  assign out_o.out_col    = s0_q ? ometa_q.col0 : ometa_q.col1;
  assign out_o.frame_last = s0_q ? ometa_q.last0 : ometa_q.last1;

  `C2DWS_ASSERT(a_win_frozen_on_stall, !adv |=> $stable(win_q), "window moved during stall")
  `C2DWS_ASSERT(a_pair_adjacent_cols,
    v5_q && meta5_q.emit0 && meta5_q.emit1 |-> meta5_q.col1 == meta5_q.col0 + 1'b1,
    "result pair not in adjacent columns")
  `C2DWS_ASSERT_NEVER(a_first_of_pair_not_last, s0_q && s1_q && ometa_q.last0,
    "first result of a pair flagged as frame end")

endmodule

// ===== rtl/conv2d_window_stream_core.sv =====
// Streaming 3x3 convolution of a raster-order Q8.8 image, one transaction per clock:
// an input pixel is accepted every cycle while the internal four-entry queue has room,
// and results leave at one per cycle while the receiver is ready. At each row end in
// same mode one pixel can yield two results, which leave one after the other; the
// queue absorbs the hold this makes. The rate is set by the single line-store port
// pair (one read, one write per cycle unless stalled) and the nine-tap multiply stage.
// In same mode a frame needs image_width drain transactions (cmd = 1) after its pixels
// to flush the last row. The user must write configuration over the APB port only
// while the stream is idle; the block itself does not enforce it.
module conv2d_window_stream_core
  import c2dws_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  c2dws_in_if.sink          in_i,
  c2dws_out_if.source       out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(MAX_WIDTH);

  // configuration registers
  cfg_t cfg_q;
  logic cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.edge_mode    <= 1'b1;
      cfg_q.image_width  <= SIZE_W'(1024);
      cfg_q.image_height <= SIZE_W'(1024);
      cfg_q.coef         <= {NTAPS{COEF_ONE}};
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_EDGE_MODE: cfg_q.edge_mode    <= pwdata[0];
        REG_WIDTH:     cfg_q.image_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT:    cfg_q.image_height <= pwdata[SIZE_W-1:0];
        REG_COEF0:     cfg_q.coef[3:0]    <= pwdata;
        REG_COEF1:     cfg_q.coef[7:4]    <= pwdata;
        REG_COEF2:     cfg_q.coef[8]      <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_EDGE_MODE: prdata = DATA_W'(cfg_q.edge_mode);
      REG_WIDTH:     prdata = DATA_W'(cfg_q.image_width);
      REG_HEIGHT:    prdata = DATA_W'(cfg_q.image_height);
      REG_COEF0:     prdata = cfg_q.coef[3:0];
      REG_COEF1:     prdata = cfg_q.coef[7:4];
      REG_COEF2:     prdata = DATA_W'(cfg_q.coef[8]);
      default:       prdata = '0;
    endcase
  end

  // front: position tracking, edge masks and result classification
  logic          push, full, pop, empty;
  logic [AW-1:0] push_addr, pop_addr;
  task_t         push_task, pop_task;

  c2dws_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .in_i  (in_i),
    .full_i(full),
    .push_o(push),
    .addr_o(push_addr),
    .task_o(push_task)
  );

  // decoupling queue between classification and arithmetic
  c2dws_queue #(
    .WIDTH(AW + TASK_W),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({push_addr, push_task}),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o({pop_addr, pop_task})
  );

  // back: line store, window, multiply and sum pipeline, output slots
  c2dws_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .empty_i(empty),
    .addr_i (pop_addr),
    .task_i (pop_task),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import c2dws_pkg::*;

  localparam int  LIMIT_CYC = 3000000;
  localparam int  SETTLE    = 24;
  localparam int  MAXW      = 1024;
  localparam int  MAXH      = 1024;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } conv_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  c2dws_in_if  pix_if ();
  c2dws_out_if res_if ();

  conv2d_window_stream_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (pix_if.sink),
    .out_o   (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor copy of the register file
  logic                    mode_q;
  logic [SIZE_W-1:0]       width_q, height_q;
  logic signed [PIX_W-1:0] tap_q [NTAPS];

  // predictor copy of the datapath state
  logic signed [PIX_W-1:0] rows_q [2][MAXW];
  logic signed [PIX_W-1:0] win_q [3][3];
  int row_cnt, col_cnt;

  conv_res_t expected_q[$];
  int  errors, n_sent, n_checked, cyc;
  int  src_idle, snk_idle, stall_left;

  initial begin
    pix_if.valid = 1'b0;
    pix_if.cmd   = 1'b0;
    pix_if.pixel = '0;
    res_if.ready = 1'b0;
    errors = 0; n_sent = 0; n_checked = 0; cyc = 0;
    src_idle = 0; snk_idle = 0; stall_left = 0;
    mode_q = 1'b1; width_q = 11'd1024; height_q = 11'd1024;
    for (int t = 0; t < NTAPS; t++) tap_q[t] = COEF_ONE;
    for (int l = 0; l < 2; l++) for (int c = 0; c < MAXW; c++) rows_q[l][c] = '0;
    for (int r = 0; r < 3; r++) for (int c = 0; c < 3; c++) win_q[r][c] = '0;
    row_cnt = 0; col_cnt = 0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYC) begin
      $display("timeout after %0d cycles, %0d results pending", cyc, expected_q.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  // receiver: random ready with optional long hold-off
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  function automatic int eff_size(logic [SIZE_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // sum over taps; taps outside the image, or shifted past the window, count as zero
  function automatic longint window_sum(int top, int left, int shift, int h, int w);
    longint s;
    int rr, cc;
    s = 0;
    for (int kr = 0; kr < 3; kr++)
      for (int kc = 0; kc < 3; kc++) begin
        rr = top + kr;
        cc = left + kc;
        if (kc + shift < 3 && rr >= 0 && rr < h && cc >= 0 && cc < w)
          s += longint'(win_q[kr][kc + shift]) * longint'(tap_q[kr * 3 + kc]);
      end
    return s;
  endfunction

  function automatic void push_result(longint s, int row, int col, bit last);
    conv_res_t e;
    e.sum  = s[SUM_W-1:0];
    e.row  = row[IDX_W-1:0];
    e.col  = col[IDX_W-1:0];
    e.last = last;
    expected_q.push_back(e);
  endfunction

  // advance the predictor by one accepted transaction
  function automatic void convolve_step(logic cmd, logic signed [PIX_W-1:0] pixel);
    logic signed [PIX_W-1:0] p;
    int w, h, r, c, ci, top, left, last_row, i;
    bit eor, eof;
    p = cmd ? '0 : pixel;
    w = eff_size(width_q, MAXW);
    h = eff_size(height_q, MAXH);
    r = row_cnt;
    c = col_cnt;
    ci = col_cnt % MAXW;
    for (int kr = 0; kr < 3; kr++)
      for (int kc = 0; kc < 2; kc++) win_q[kr][kc] = win_q[kr][kc + 1];
    win_q[0][2] = rows_q[0][ci];
    win_q[1][2] = rows_q[1][ci];
    win_q[2][2] = p;
    rows_q[0][ci] = rows_q[1][ci];
    rows_q[1][ci] = p;
    top  = r - 2;
    left = c - 2;
    eor  = (c >= w - 1);
    last_row = mode_q ? h - 1 + PAD : h - 1;
    eof  = eor && (r >= last_row);
    if (!mode_q) begin
      if (top >= 0 && left >= 0) push_result(window_sum(top, left, 0, h, w), top, left, eof);
    end else begin
      i = r - PAD;
      if (i >= 0) begin
        if (c - PAD >= 0)
          push_result(window_sum(top, left, 0, h, w), i, c - PAD, eof && PAD == 0);
        if (eor)
          for (int e = 1; e <= PAD; e++)
            push_result(window_sum(top, left + e, e, h, w), i, c - PAD + e, eof && e == PAD);
      end
    end
    if (eor) begin
      col_cnt = 0;
      row_cnt = (r >= last_row) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endfunction

  // input monitor feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      convolve_step(pix_if.cmd, pix_if.pixel);
      n_sent++;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    conv_res_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result row %0d col %0d sum %h", res_if.out_row,
                   res_if.out_col, res_if.sum_value);
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (e.sum !== res_if.sum_value || e.row !== res_if.out_row ||
            e.col !== res_if.out_col || e.last !== res_if.frame_last) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp sum %h row %0d col %0d last %0d,",
                      " got sum %h row %0d col %0d last %0d"},
                     e.sum, e.row, e.col, e.last, res_if.sum_value, res_if.out_row,
                     res_if.out_col, res_if.frame_last);
        end
      end
    end
  end

  // register write over the apb port, starts and ends at a falling edge
  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 3'b000}); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_EDGE_MODE: mode_q = val[0];
      REG_WIDTH:     width_q = val[SIZE_W-1:0];
      REG_HEIGHT:    height_q = val[SIZE_W-1:0];
      REG_COEF0:     for (int t = 0; t < 4; t++) tap_q[t] = val[16*t +: 16];
      REG_COEF1:     for (int t = 0; t < 4; t++) tap_q[4 + t] = val[16*t +: 16];
      REG_COEF2:     tap_q[8] = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(bit mode, int w, int h);
    write_reg(REG_EDGE_MODE, DATA_W'(mode));
    write_reg(REG_WIDTH, DATA_W'(w));
    write_reg(REG_HEIGHT, DATA_W'(h));
  endtask

  task automatic set_coefs(logic [63:0] g0, logic [63:0] g1, logic [15:0] g2);
    write_reg(REG_COEF0, g0);
    write_reg(REG_COEF1, g1);
    write_reg(REG_COEF2, DATA_W'(g2));
  endtask

  // one transaction on the pixel channel; starts and ends at a falling edge
  task automatic send_pixel(logic cmd, logic signed [PIX_W-1:0] pixel);
    while ($urandom_range(99) < src_idle) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.cmd   <= cmd;
    pix_if.pixel <= pixel;
    do @(posedge clk_i); while (!pix_if.ready);
    @(negedge clk_i);
  endtask

  task automatic go_quiet();
    pix_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] rand_pix();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_coefs();
    if ($urandom_range(4) == 0) return {4{rand_pix()}};
    return {$urandom, $urandom};
  endfunction

  // a whole frame in raster order, with optional noise inside the image and drain rows
  task automatic send_frame(bit mode, int w, int h, int noise_pct);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        send_pixel($urandom_range(99) < noise_pct, rand_pix());
    if (mode)
      for (int c = 0; c < w * PAD; c++)
        send_pixel(!($urandom_range(99) < noise_pct), rand_pix());
  endtask

  // extremes of pixels and taps, drains inside the image and a pixel in the drain row
  task automatic test_directed();
    set_coefs(64'h7fff_8000_7fff_8000, 64'h8000_7fff_0000_ffff, 16'h8000);
    set_shape(1'b0, 3, 3);
    for (int k = 0; k < 9; k++)
      send_pixel(k == 4, (k % 2) ? 16'sh7fff : 16'sh8000);
    go_quiet();
    set_shape(1'b1, 2, 2);
    send_pixel(1'b0, 16'sh8000);
    send_pixel(1'b1, 16'sh7fff);
    send_pixel(1'b0, 16'sh7fff);
    send_pixel(1'b0, 16'sh0100);
    send_pixel(1'b0, 16'sh1234);   // pixel offered in a drain row
    send_pixel(1'b1, 16'sh0000);
    go_quiet();
    // image narrower than the kernel in valid mode gives nothing
    set_shape(1'b0, 2, 5);
    for (int k = 0; k < 10; k++) send_pixel(1'b0, rand_pix());
    go_quiet();
  endtask

  // random frames under one idle profile
  task automatic test_random_frames(int s_idle, int r_idle, int budget);
    int start, w, h;
    bit mode;
    src_idle = s_idle;
    snk_idle = r_idle;
    start = n_sent;
    while (n_sent - start < budget) begin
      mode = $urandom_range(1);
      w = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 7);
      set_coefs(rand_coefs(), rand_coefs(), rand_pix());
      set_shape(mode, w, h);
      send_frame(mode, w, h, ($urandom_range(3) == 0) ? 15 : 0);
      go_quiet();
    end
  endtask

  // zero sizes and a wide frame
  task automatic test_size_limits();
    src_idle = 0;
    snk_idle = 10;
    set_coefs(rand_coefs(), rand_coefs(), rand_pix());
    set_shape(1'b0, 0, 0);          // acts as 1 x 1
    for (int k = 0; k < 3; k++) send_pixel(1'b0, rand_pix());
    go_quiet();
    set_shape(1'b1, 0, 3);          // acts as 1 x 3
    send_frame(1'b1, 1, 3, 0);
    go_quiet();
    set_shape(1'b1, 5, 0);          // acts as 5 x 1
    send_frame(1'b1, 5, 1, 0);
    go_quiet();
    set_shape(1'b0, 64, 3);
    send_frame(1'b0, 64, 3, 5);
    go_quiet();
  endtask

  // receiver holds off long enough that the input stalls
  task automatic test_backpressure();
    src_idle = 0;
    snk_idle = 0;
    set_shape(1'b1, 8, 8);
    @(negedge clk_i);
    stall_left = 300;
    send_frame(1'b1, 8, 8, 0);
    go_quiet();
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_frames(15, 45, 250);
    test_random_frames(45, 15, 250);
    test_random_frames(0, 0, 250);
    test_size_limits();
    test_backpressure();
    go_quiet();
    $display("covered: valid and same modes, random kernels and sizes, zero sizes,");
    $display("  drain noise and long output stall; %0d transactions in, %0d results checked",
             n_sent, n_checked);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_q.size());
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
